// ----- rtl/rlcseg_pkg.sv -----
// Shared constants, codes and types of the RLC UM transmit segmenter.
`default_nettype none
package rlcseg_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SN_BITS     = 10;
    localparam int MAX_PIECES  = 16;
    localparam int PCNT_W      = $clog2(MAX_PIECES + 1);

    localparam int LEN_W      = 16;
    localparam int TAG_W      = 16;
    localparam int BYTES_W    = 20;
    localparam int HDR_W      = 4;
    localparam int SN_OUT_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // input operations
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_BUILD   = 2'd1;
    localparam logic [1:0] OP_DROP    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_PIECE   = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_ACK     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER      = 2'd1;

    localparam logic [HDR_W-1:0] HEADER_RESET = 4'd2;

    typedef struct packed {
        logic [BYTES_W-1:0] limit;
        logic [HDR_W-1:0]   hdr;
    } t_cfg;

    typedef struct packed {
        logic              we_len;
        logic              we_tag;
        logic [QIDX_W-1:0] waddr;
        logic [LEN_W-1:0]  wlen;
        logic [TAG_W-1:0]  wtag;
        logic [QIDX_W-1:0] raddr;
    } t_mem_req;

endpackage
`default_nettype wire

// ----- rtl/rlc_um_tx_segmenter_top.sv -----
// Top level of the RLC UM transmit segmenter: config registers, descriptor RAMs, sequencer.
//
// SDU descriptors (tag, length) wait in a 16-entry ring held in two small RAMs.
// Every operation is taken one at a time; the input is not ready until the last
// result of the current operation has been loaded into the output register.
// Drop first reads the newest length from the descriptor RAM. A PDU build gives
// either one empty PDU or one result per piece, up to 16 pieces: the single read
// port of the descriptor RAM and the shared byte-count unit handle one descriptor
// per cycle while the result channel is not stalled, reading the next head ahead
// of use. Back-pressure on the result channel holds the current operation.
// Configuration is taken at any cycle the write enable is high; writes to unknown
// indexes are dropped.
`default_nettype none
module rlc_um_tx_segmenter_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rlcseg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rlcseg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [1:0]                          i_op,
    input  wire logic [rlcseg_pkg::LEN_W-1:0]        i_sdu_length,
    input  wire logic [rlcseg_pkg::TAG_W-1:0]        i_sdu_tag,
    input  wire logic [rlcseg_pkg::LEN_W-1:0]        i_grant_bytes,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [1:0]                               o_kind,
    output logic                                     o_accepted,
    output logic [rlcseg_pkg::TAG_W-1:0]             o_piece_tag,
    output logic [rlcseg_pkg::LEN_W-1:0]             o_piece_bytes,
    output logic [rlcseg_pkg::SN_OUT_W-1:0]          o_pdu_sequence,
    output logic [1:0]                               o_framing_info,
    output logic [rlcseg_pkg::LEN_W-1:0]             o_pdu_bytes,
    output logic                                     o_last
);

    rlcseg_pkg::t_cfg     r_cfg;
    rlcseg_pkg::t_mem_req mem_req;
    logic [rlcseg_pkg::LEN_W-1:0] mem_len;
    logic [rlcseg_pkg::TAG_W-1:0] mem_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit <= '0;
            r_cfg.hdr   <= rlcseg_pkg::HEADER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rlcseg_pkg::CFG_QUEUE_LIMIT: r_cfg.limit <= i_cfg_data[rlcseg_pkg::BYTES_W-1:0];
                rlcseg_pkg::CFG_HEADER:      r_cfg.hdr   <= i_cfg_data[rlcseg_pkg::HDR_W-1:0];
                default: ;
            endcase
        end
    end

    rlcseg_ram #(
        .WIDTH (rlcseg_pkg::LEN_W),
        .DEPTH (rlcseg_pkg::QUEUE_DEPTH)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we_len),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wlen),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_len)
    );

    rlcseg_ram #(
        .WIDTH (rlcseg_pkg::TAG_W),
        .DEPTH (rlcseg_pkg::QUEUE_DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we_tag),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wtag),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_tag)
    );

    rlcseg_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_sdu_length   (i_sdu_length),
        .i_sdu_tag      (i_sdu_tag),
        .i_grant_bytes  (i_grant_bytes),
        .o_mem          (mem_req),
        .i_mem_len      (mem_len),
        .i_mem_tag      (mem_tag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_accepted     (o_accepted),
        .o_piece_tag    (o_piece_tag),
        .o_piece_bytes  (o_piece_bytes),
        .o_pdu_sequence (o_pdu_sequence),
        .o_framing_info (o_framing_info),
        .o_pdu_bytes    (o_pdu_bytes),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

// ----- rtl/rlcseg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rlcseg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/rlcseg_alu.sv -----
// Shared byte-count unit: add with carry out, or subtract saturating at zero.
`default_nettype none
module rlcseg_alu (
    input  wire logic [rlcseg_pkg::BYTES_W-1:0] i_a,
    input  wire logic [rlcseg_pkg::LEN_W-1:0]   i_b,
    input  wire logic                           i_sub,
    output logic      [rlcseg_pkg::BYTES_W:0]   o_y
);

    logic [rlcseg_pkg::BYTES_W:0] b_ext;
    logic [rlcseg_pkg::BYTES_W:0] a_ext;

    always_comb begin
        a_ext = {1'b0, i_a};
        b_ext = (rlcseg_pkg::BYTES_W + 1)'(i_b);
        if (i_sub) begin
            o_y = (a_ext >= b_ext) ? a_ext - b_ext : '0;
        end else begin
            o_y = a_ext + b_ext;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rlcseg_seq.sv -----
// Sequencer and queue state: runs one operation at a time, one piece per cycle while the result channel is not stalled.
`default_nettype none
module rlcseg_seq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rlcseg_pkg::t_cfg                  i_cfg,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [1:0]                        i_op,
    input  wire logic [rlcseg_pkg::LEN_W-1:0]      i_sdu_length,
    input  wire logic [rlcseg_pkg::TAG_W-1:0]      i_sdu_tag,
    input  wire logic [rlcseg_pkg::LEN_W-1:0]      i_grant_bytes,
    output rlcseg_pkg::t_mem_req                   o_mem,
    input  wire logic [rlcseg_pkg::LEN_W-1:0]      i_mem_len,
    input  wire logic [rlcseg_pkg::TAG_W-1:0]      i_mem_tag,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [1:0]                             o_kind,
    output logic                                   o_accepted,
    output logic [rlcseg_pkg::TAG_W-1:0]           o_piece_tag,
    output logic [rlcseg_pkg::LEN_W-1:0]           o_piece_bytes,
    output logic [rlcseg_pkg::SN_OUT_W-1:0]        o_pdu_sequence,
    output logic [1:0]                             o_framing_info,
    output logic [rlcseg_pkg::LEN_W-1:0]           o_pdu_bytes,
    output logic                                   o_last
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ENQ     = 3'd1;
    localparam logic [2:0] S_START   = 3'd2;
    localparam logic [2:0] S_PIECE   = 3'd3;
    localparam logic [2:0] S_DROP_RD = 3'd4;
    localparam logic [2:0] S_DROP_EX = 3'd5;
    localparam logic [2:0] S_CLEAR   = 3'd6;

    localparam int QIDX_W  = rlcseg_pkg::QIDX_W;
    localparam int QCNT_W  = rlcseg_pkg::QCNT_W;
    localparam int PCNT_W  = rlcseg_pkg::PCNT_W;
    localparam int LEN_W   = rlcseg_pkg::LEN_W;
    localparam int TAG_W   = rlcseg_pkg::TAG_W;
    localparam int BYTES_W = rlcseg_pkg::BYTES_W;
    localparam int SN_BITS = rlcseg_pkg::SN_BITS;

    logic [2:0]         r_state, n_state;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic [LEN_W-1:0]   r_grant, n_grant;
    logic [LEN_W-1:0]   r_room, n_room;
    logic [LEN_W-1:0]   r_total, n_total;
    logic [PCNT_W-1:0]  r_npc, n_npc;
    logic               r_start_rem, n_start_rem;
    logic [QIDX_W-1:0]  r_head, n_head;
    logic [QIDX_W-1:0]  r_tail, n_tail;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic [BYTES_W-1:0] r_queued, n_queued;
    logic               r_rem, n_rem;
    logic [SN_BITS-1:0] r_sn, n_sn;

    logic                          r_out_valid, n_out_valid;
    logic [1:0]                    r_kind, n_kind;
    logic                          r_acc, n_acc;
    logic [TAG_W-1:0]              r_ptag, n_ptag;
    logic [LEN_W-1:0]              r_pbytes, n_pbytes;
    logic [rlcseg_pkg::SN_OUT_W-1:0] r_osn, n_osn;
    logic [1:0]                    r_fi, n_fi;
    logic [LEN_W-1:0]              r_pdu, n_pdu;
    logic                          r_last, n_last;

    logic               out_free;
    logic [LEN_W-1:0]   hdr16;
    logic [LEN_W-1:0]   room_calc;
    logic               whole;
    logic [LEN_W-1:0]   take;
    logic [LEN_W-1:0]   room_after;
    logic [QCNT_W-1:0]  count_after;
    logic [PCNT_W-1:0]  npc_inc;
    logic [LEN_W-1:0]   total_after;
    logic               fin;
    logic               enq_ok;
    logic [QIDX_W-1:0]  prev_tail;
    logic [LEN_W-1:0]   alu_b;
    logic               alu_sub;
    logic [BYTES_W:0]   alu_y;
    logic [15:0]        sn_wide;

    function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] i);
        return (i == QIDX_W'(rlcseg_pkg::QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [QIDX_W-1:0] prev_slot(input logic [QIDX_W-1:0] i);
        return (i == '0) ? QIDX_W'(rlcseg_pkg::QUEUE_DEPTH - 1) : i - 1'b1;
    endfunction

    rlcseg_alu u_alu (
        .i_a   (r_queued),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_y   (alu_y)
    );

    assign out_free  = !r_out_valid || i_ready;
    assign hdr16     = LEN_W'(i_cfg.hdr);
    assign prev_tail = prev_slot(r_tail);
    assign sn_wide   = 16'(r_sn);

    // piece arithmetic against the head descriptor
    assign room_calc   = (r_grant > hdr16) ? r_grant - hdr16 : '0;
    assign whole       = r_room >= i_mem_len;
    assign take        = whole ? i_mem_len : r_room;
    assign room_after  = r_room - take;
    assign count_after = r_count - QCNT_W'(whole);
    assign npc_inc     = r_npc + 1'b1;
    assign total_after = r_total + take;
    assign fin         = (count_after == '0) || (room_after == '0) ||
                         (npc_inc >= PCNT_W'(rlcseg_pkg::MAX_PIECES));

    assign enq_ok = (r_count < QCNT_W'(rlcseg_pkg::QUEUE_DEPTH)) && (r_len != '0) &&
                    !alu_y[BYTES_W] &&
                    ((i_cfg.limit == '0) || (alu_y[BYTES_W-1:0] < i_cfg.limit));

    always_comb begin
        case (r_state)
            S_ENQ:     begin alu_b = r_len;     alu_sub = 1'b0; end
            S_PIECE:   begin alu_b = take;      alu_sub = 1'b1; end
            default:   begin alu_b = i_mem_len; alu_sub = 1'b1; end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_tag       = r_tag;
        n_grant     = r_grant;
        n_room      = r_room;
        n_total     = r_total;
        n_npc       = r_npc;
        n_start_rem = r_start_rem;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_queued    = r_queued;
        n_rem       = r_rem;
        n_sn        = r_sn;

        n_out_valid = r_out_valid && !i_ready;
        n_kind      = r_kind;
        n_acc       = r_acc;
        n_ptag      = r_ptag;
        n_pbytes    = r_pbytes;
        n_osn       = r_osn;
        n_fi        = r_fi;
        n_pdu       = r_pdu;
        n_last      = r_last;

        o_mem.we_len = 1'b0;
        o_mem.we_tag = 1'b0;
        o_mem.waddr  = r_tail;
        o_mem.wlen   = r_len;
        o_mem.wtag   = r_tag;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_len   = i_sdu_length;
                    n_tag   = i_sdu_tag;
                    n_grant = i_grant_bytes;
                    case (i_op)
                        rlcseg_pkg::OP_ENQUEUE: n_state = S_ENQ;
                        rlcseg_pkg::OP_BUILD:   n_state = S_START;
                        rlcseg_pkg::OP_DROP:    n_state = S_DROP_RD;
                        default:                n_state = S_CLEAR;
                    endcase
                end
            end
            S_ENQ: begin
                if (out_free) begin
                    if (enq_ok) begin
                        o_mem.we_len = 1'b1;
                        o_mem.we_tag = 1'b1;
                        n_tail   = next_slot(r_tail);
                        n_count  = r_count + 1'b1;
                        n_queued = alu_y[BYTES_W-1:0];
                    end
                    n_out_valid = 1'b1;
                    n_kind   = rlcseg_pkg::KIND_VERDICT;
                    n_acc    = enq_ok;
                    n_ptag   = '0;
                    n_pbytes = '0;
                    n_osn    = '0;
                    n_fi     = '0;
                    n_pdu    = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_START: begin
                n_room      = room_calc;
                n_total     = '0;
                n_npc       = '0;
                n_start_rem = r_rem;
                if ((r_count == '0) || (room_calc == '0)) begin
                    // no room or no data: one empty PDU, nothing else moves
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_kind   = rlcseg_pkg::KIND_EMPTY;
                        n_acc    = 1'b0;
                        n_ptag   = '0;
                        n_pbytes = '0;
                        n_osn    = '0;
                        n_fi     = '0;
                        n_pdu    = '0;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_PIECE;
                end
            end
            S_PIECE: begin
                if (out_free) begin
                    n_room   = room_after;
                    n_total  = total_after;
                    n_npc    = npc_inc;
                    n_count  = count_after;
                    n_queued = alu_y[BYTES_W-1:0];
                    if (whole) begin
                        n_head = next_slot(r_head);
                        n_rem  = 1'b0;
                    end else begin
                        // cut the head: keep the remainder in place
                        o_mem.we_len = 1'b1;
                        o_mem.waddr  = r_head;
                        o_mem.wlen   = i_mem_len - take;
                        n_rem        = 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_kind   = rlcseg_pkg::KIND_PIECE;
                    n_acc    = 1'b0;
                    n_ptag   = i_mem_tag;
                    n_pbytes = take;
                    n_osn    = '0;
                    n_fi     = '0;
                    n_pdu    = '0;
                    n_last   = 1'b0;
                    if (fin) begin
                        n_osn   = sn_wide[rlcseg_pkg::SN_OUT_W-1:0];
                        n_fi    = {r_start_rem, !whole};
                        n_pdu   = hdr16 + total_after;
                        n_last  = 1'b1;
                        n_sn    = r_sn + 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_DROP_RD: begin
                n_state = S_DROP_EX;
            end
            S_DROP_EX: begin
                if (out_free) begin
                    if (r_count != '0) begin
                        n_queued = alu_y[BYTES_W-1:0];
                        n_tail   = prev_tail;
                        n_count  = r_count - 1'b1;
                        if (r_count == QCNT_W'(1)) begin
                            n_rem = 1'b0;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_kind   = rlcseg_pkg::KIND_ACK;
                    n_acc    = 1'b0;
                    n_ptag   = '0;
                    n_pbytes = '0;
                    n_osn    = '0;
                    n_fi     = '0;
                    n_pdu    = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (out_free) begin
                    n_head   = '0;
                    n_tail   = '0;
                    n_count  = '0;
                    n_queued = '0;
                    n_rem    = 1'b0;
                    n_out_valid = 1'b1;
                    n_kind   = rlcseg_pkg::KIND_ACK;
                    n_acc    = 1'b0;
                    n_ptag   = '0;
                    n_pbytes = '0;
                    n_osn    = '0;
                    n_fi     = '0;
                    n_pdu    = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // read ahead: next head, or the newest entry for a drop (held while the ack stalls)
        o_mem.raddr = (r_state inside {S_DROP_RD, S_DROP_EX}) ? prev_tail : n_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_queued    <= '0;
            r_rem       <= 1'b0;
            r_sn        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_queued    <= n_queued;
            r_rem       <= n_rem;
            r_sn        <= n_sn;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_tag       <= n_tag;
        r_grant     <= n_grant;
        r_room      <= n_room;
        r_total     <= n_total;
        r_npc       <= n_npc;
        r_start_rem <= n_start_rem;
        r_kind      <= n_kind;
        r_acc       <= n_acc;
        r_ptag      <= n_ptag;
        r_pbytes    <= n_pbytes;
        r_osn       <= n_osn;
        r_fi        <= n_fi;
        r_pdu       <= n_pdu;
        r_last      <= n_last;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_accepted     = r_acc;
    assign o_piece_tag    = r_ptag;
    assign o_piece_bytes  = r_pbytes;
    assign o_pdu_sequence = r_osn;
    assign o_framing_info = r_fi;
    assign o_pdu_bytes    = r_pdu;
    assign o_last         = r_last;

endmodule
`default_nettype wire

// ----- rtl/rlcseg_checker.sv -----
// Port-level checks of the segmenter, bound to the top level.
`default_nettype none
module rlcseg_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_valid,
    input wire logic                                o_ready,
    input wire logic                                o_valid,
    input wire logic                                i_ready,
    input wire logic [1:0]                          o_kind,
    input wire logic [rlcseg_pkg::TAG_W-1:0]        o_piece_tag,
    input wire logic [rlcseg_pkg::LEN_W-1:0]        o_piece_bytes,
    input wire logic [rlcseg_pkg::LEN_W-1:0]        o_pdu_bytes,
    input wire logic                                o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_piece_tag) &&
            $stable(o_piece_bytes) && $stable(o_pdu_bytes) && $stable(o_last))
        else $error("stalled result changed");

    // one operation at a time: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after a transfer");

    // only PDU pieces may be followed by more results of the same item
    a_non_last_is_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_kind == rlcseg_pkg::KIND_PIECE)
        else $error("non-final result that is not a piece");

    // an empty PDU is a single result with no length
    a_empty_pdu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == rlcseg_pkg::KIND_EMPTY) |-> o_last && (o_pdu_bytes == '0))
        else $error("malformed empty PDU");

endmodule

bind rlc_um_tx_segmenter_top rlcseg_checker u_rlcseg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_kind        (o_kind),
    .o_piece_tag   (o_piece_tag),
    .o_piece_bytes (o_piece_bytes),
    .o_pdu_bytes   (o_pdu_bytes),
    .o_last        (o_last)
);
`default_nettype wire

// ----- tb/rlc_um_tx_segmenter_top_test.sv -----
// Self-checking testbench of the RLC UM transmit segmenter: directed cases, then random traffic.
`timescale 1ns / 1ps
module rlc_um_tx_segmenter_top_test;
    import rlcseg_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TIME  = 20;
    localparam int SEQ_BUILDS   = 12;
    localparam int RANDOM_ITEMS = 8;
    localparam int BYTES_MAX    = (1 << BYTES_W) - 1;

    // indexes past the register map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic                accepted;
        logic [TAG_W-1:0]    piece_tag;
        logic [LEN_W-1:0]    piece_bytes;
        logic [SN_OUT_W-1:0] pdu_sequence;
        logic [1:0]          framing_info;
        logic [LEN_W-1:0]    pdu_bytes;
        logic                last;
    } rlc_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_op = OP_ENQUEUE;
    logic [LEN_W-1:0]      i_sdu_length = '0;
    logic [TAG_W-1:0]      i_sdu_tag = '0;
    logic [LEN_W-1:0]      i_grant_bytes = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [1:0]            o_kind;
    logic                  o_accepted;
    logic [TAG_W-1:0]      o_piece_tag;
    logic [LEN_W-1:0]      o_piece_bytes;
    logic [SN_OUT_W-1:0]   o_pdu_sequence;
    logic [1:0]            o_framing_info;
    logic [LEN_W-1:0]      o_pdu_bytes;
    logic                  o_last;

    rlc_um_tx_segmenter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_sdu_length   (i_sdu_length),
        .i_sdu_tag      (i_sdu_tag),
        .i_grant_bytes  (i_grant_bytes),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_accepted     (o_accepted),
        .o_piece_tag    (o_piece_tag),
        .o_piece_bytes  (o_piece_bytes),
        .o_pdu_sequence (o_pdu_sequence),
        .o_framing_info (o_framing_info),
        .o_pdu_bytes    (o_pdu_bytes),
        .o_last         (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the block: configuration, descriptor ring, framing state
    logic [BYTES_W-1:0] cfg_limit = '0;
    logic [HDR_W-1:0]   cfg_hdr = HEADER_RESET;
    logic [LEN_W-1:0]   ring_len [QUEUE_DEPTH];
    logic [TAG_W-1:0]   ring_tag [QUEUE_DEPTH];
    logic [QIDX_W-1:0]  ring_head = '0;
    logic [QIDX_W-1:0]  ring_tail = '0;
    int                 ring_count = 0;
    logic [BYTES_W-1:0] ring_bytes = '0;
    logic               head_cut = 1'b0;
    logic [SN_BITS-1:0] next_sn = '0;

    rlc_result_t rlc_results_due[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    logic        no_idle = 1'b0;

    // Work out the results of one accepted operation and queue them in order.
    task automatic predict_rlc_op(input logic [1:0] op, input logic [LEN_W-1:0] len,
                                  input logic [TAG_W-1:0] tag,
                                  input logic [LEN_W-1:0] grant);
        int unsigned sum;
        int unsigned room;
        int unsigned take;
        int unsigned total;
        int          pieces;
        logic        ok;
        logic        starts_rem;
        logic        ends_cut;
        rlc_result_t r;
        r = '0;
        r.last = 1'b1;
        case (op)
            OP_ENQUEUE: begin
                sum = ring_bytes + len;
                ok = (ring_count < QUEUE_DEPTH) && (len != 0) && (sum <= BYTES_MAX) &&
                     ((cfg_limit == 0) || (sum < cfg_limit));
                if (ok) begin
                    ring_len[ring_tail] = len;
                    ring_tag[ring_tail] = tag;
                    ring_tail = ring_tail + 1'b1;
                    ring_count++;
                    ring_bytes = BYTES_W'(sum);
                end
                r.kind = KIND_VERDICT;
                r.accepted = ok;
                rlc_results_due.push_back(r);
            end
            OP_BUILD: begin
                room = (grant > cfg_hdr) ? grant - cfg_hdr : 0;
                total = 0;
                pieces = 0;
                starts_rem = head_cut;
                ends_cut = 1'b0;
                while (ring_count > 0 && room > 0 && pieces < MAX_PIECES) begin
                    // hold back the previous piece: only the final one gets the trailer
                    if (pieces > 0) rlc_results_due.push_back(r);
                    r = '0;
                    r.kind = KIND_PIECE;
                    r.piece_tag = ring_tag[ring_head];
                    if (room >= ring_len[ring_head]) begin
                        take = ring_len[ring_head];
                        ring_head = ring_head + 1'b1;
                        ring_count--;
                        head_cut = 1'b0;
                    end else begin
                        take = room;
                        ring_len[ring_head] = LEN_W'(ring_len[ring_head] - take);
                        head_cut = 1'b1;
                        ends_cut = 1'b1;
                    end
                    r.piece_bytes = LEN_W'(take);
                    room -= take;
                    total += take;
                    ring_bytes = BYTES_W'((ring_bytes >= take) ? ring_bytes - take : 0);
                    pieces++;
                end
                if (total == 0) begin
                    r = '0;
                    r.kind = KIND_EMPTY;
                end else begin
                    r.pdu_sequence = next_sn;
                    r.framing_info = {starts_rem, ends_cut};
                    r.pdu_bytes = LEN_W'(cfg_hdr + total);
                    next_sn = next_sn + 1'b1;
                end
                r.last = 1'b1;
                rlc_results_due.push_back(r);
            end
            OP_DROP: begin
                if (ring_count > 0) begin
                    ring_tail = ring_tail - 1'b1;
                    ring_bytes = (ring_bytes >= ring_len[ring_tail]) ?
                                 ring_bytes - ring_len[ring_tail] : '0;
                    ring_count--;
                    if (ring_count == 0) head_cut = 1'b0;
                end
                r.kind = KIND_ACK;
                rlc_results_due.push_back(r);
            end
            default: begin
                ring_head = '0;
                ring_tail = '0;
                ring_count = 0;
                ring_bytes = '0;
                head_cut = 1'b0;
                r.kind = KIND_ACK;
                rlc_results_due.push_back(r);
            end
        endcase
    endtask

    // Present one operation after a random gap and hold it until the transfer.
    task automatic send_item(input logic [1:0] op, input logic [LEN_W-1:0] len,
                             input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] grant);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_sdu_length <= len;
        i_sdu_tag <= tag;
        i_grant_bytes <= grant;
        do @(posedge i_clk); while (!o_ready);
        predict_rlc_op(op, len, tag, grant);
    endtask

    task automatic enqueue_sdu(input logic [LEN_W-1:0] len, input logic [TAG_W-1:0] tag);
        send_item(OP_ENQUEUE, len, tag, LEN_W'($urandom));
    endtask

    task automatic grant_pdu(input logic [LEN_W-1:0] grant);
        send_item(OP_BUILD, LEN_W'($urandom), TAG_W'($urandom), grant);
    endtask

    task automatic send_ctrl(input logic [1:0] op);
        send_item(op, LEN_W'($urandom), TAG_W'($urandom), LEN_W'($urandom));
    endtask

    // Drop valid and wait until every predicted result has been taken.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (rlc_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_QUEUE_LIMIT) cfg_limit = data;
        else if (idx == CFG_HEADER) cfg_hdr = data[HDR_W-1:0];
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Result side: random stall per result, compare each transfer with the oldest prediction.
    initial begin : result_checker
        rlc_result_t want;
        int          stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (rlc_results_due.size() == 0) begin
                $error("result transfer with nothing pending: kind %0d", o_kind);
                error_count++;
            end else begin
                want = rlc_results_due.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("accepted", want.accepted, o_accepted);
                check_field("piece_tag", want.piece_tag, o_piece_tag);
                check_field("piece_bytes", want.piece_bytes, o_piece_bytes);
                check_field("pdu_sequence", want.pdu_sequence, o_pdu_sequence);
                check_field("framing_info", want.framing_info, o_framing_info);
                check_field("pdu_bytes", want.pdu_bytes, o_pdu_bytes);
                check_field("last", want.last, o_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Empty queue, zero length, grants at or below the header, a cut and its remainder.
    task automatic test_empty_and_refusals();
        grant_pdu(16'd100);
        send_ctrl(OP_DROP);
        send_ctrl(OP_CLEAR);
        enqueue_sdu(16'd0, 16'h1234);
        enqueue_sdu(16'd10, 16'hFFFF);
        grant_pdu(16'd0);
        grant_pdu(16'd2);
        grant_pdu(16'd5);
        grant_pdu(16'hFFFF);
    endtask

    // Strict byte limit, largest header, writes to unused indexes.
    task automatic test_limit_and_header();
        wait_idle();
        write_cfg(CFG_QUEUE_LIMIT, 20'd100);
        write_cfg(CFG_HEADER, 20'd15);
        write_cfg(CFG_SPARE_A, 20'hFFFFF);
        write_cfg(CFG_SPARE_B, 20'h00001);
        enqueue_sdu(16'd60, 16'h0001);
        enqueue_sdu(16'd40, 16'h0002);
        enqueue_sdu(16'd39, 16'h0003);
        grant_pdu(16'd16);
        grant_pdu(16'd15);
        send_ctrl(OP_CLEAR);
        wait_idle();
        write_cfg(CFG_QUEUE_LIMIT, 20'd1);
        write_cfg(CFG_HEADER, 20'd0);
        enqueue_sdu(16'd1, 16'h0004);
        wait_idle();
        write_cfg(CFG_QUEUE_LIMIT, 20'hFFFFF);
        enqueue_sdu(16'hFFFF, 16'h8000);
        grant_pdu(16'd1);
        send_ctrl(OP_CLEAR);
    endtask

    // Cut followed by drop of the cut SDU, remainder plus cut, clear with a remainder pending.
    task automatic test_cut_drop_clear();
        wait_idle();
        write_cfg(CFG_QUEUE_LIMIT, 20'd0);
        write_cfg(CFG_HEADER, 20'd2);
        enqueue_sdu(16'd20, 16'h0000);
        enqueue_sdu(16'd30, 16'h00A5);
        grant_pdu(16'd27);
        send_ctrl(OP_DROP);
        enqueue_sdu(16'd10, 16'h5A00);
        grant_pdu(16'd1000);
        enqueue_sdu(16'd40, 16'h0F0F);
        grant_pdu(16'd12);
        grant_pdu(16'd12);
        send_ctrl(OP_CLEAR);
        enqueue_sdu(16'd5, 16'hF0F0);
        grant_pdu(16'd100);
    endtask

    // Fill every descriptor, refuse one more, then take all sixteen into one PDU, the last one cut.
    task automatic test_full_queue();
        wait_idle();
        write_cfg(CFG_HEADER, 20'd0);
        for (int i = 1; i < QUEUE_DEPTH; i++) enqueue_sdu(LEN_W'(i), TAG_W'($urandom));
        enqueue_sdu(16'hFFFF, 16'hFFFF);
        enqueue_sdu(16'd7, 16'h0007);
        grant_pdu(16'hFFFF);
        send_ctrl(OP_DROP);
        enqueue_sdu(16'd3, 16'h0003);
        grant_pdu(16'd50);
    endtask

    // One long SDU cut a byte at a time: the sequence number advances on every PDU.
    task automatic test_sequence_advance();
        wait_idle();
        write_cfg(CFG_HEADER, 20'd0);
        write_cfg(CFG_QUEUE_LIMIT, 20'd0);
        send_ctrl(OP_CLEAR);
        enqueue_sdu(16'd1100, 16'hC3C3);
        for (int i = 0; i < SEQ_BUILDS; i++) grant_pdu(16'd1);
        send_ctrl(OP_CLEAR);
    endtask

    // Mixed traffic in four configuration phases, mostly enqueues and grants.
    task automatic test_random_traffic();
        int                 pick;
        logic [1:0]         op;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   grant;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_cfg(CFG_QUEUE_LIMIT, 20'd0);
                    write_cfg(CFG_HEADER, CFG_DATA_W'($urandom_range(0, 15)));
                end
                1: begin
                    write_cfg(CFG_QUEUE_LIMIT, CFG_DATA_W'($urandom_range(200, 3000)));
                    write_cfg(CFG_HEADER, 20'd15);
                end
                2: begin
                    write_cfg(CFG_QUEUE_LIMIT, 20'hFFFFF);
                    write_cfg(CFG_HEADER, 20'd0);
                end
                default: begin
                    write_cfg(CFG_QUEUE_LIMIT, CFG_DATA_W'($urandom_range(1, 20'hFFFFF)));
                    write_cfg(CFG_HEADER, CFG_DATA_W'($urandom_range(0, 15)));
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                no_idle = (phase == 1) && (n < 12);
                pick = $urandom_range(0, 99);
                op = (pick < 50) ? OP_ENQUEUE : (pick < 85) ? OP_BUILD :
                     (pick < 95) ? OP_DROP : OP_CLEAR;
                pick = $urandom_range(0, 99);
                len = LEN_W'((pick < 3)  ? 0 :
                             (pick < 75) ? $urandom_range(1, 300) :
                             (pick < 95) ? $urandom_range(301, 5000) :
                                           $urandom_range(5001, 65535));
                pick = $urandom_range(0, 99);
                grant = LEN_W'((pick < 5)  ? 0 :
                               (pick < 10) ? {12'd0, cfg_hdr} :
                               (pick < 80) ? $urandom_range(1, 400) :
                               (pick < 95) ? $urandom_range(401, 8000) :
                                             $urandom_range(8001, 65535));
                send_item(op, len, TAG_W'($urandom), grant);
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_refusals();
        test_limit_and_header();
        test_cut_drop_clear();
        test_full_queue();
        test_sequence_advance();
        test_random_traffic();
        wait_idle();
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (error_count == 0 && rlc_results_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rlcseg_pkg.sv
rtl/rlcseg_ram.sv
rtl/rlcseg_alu.sv
rtl/rlcseg_seq.sv
rtl/rlc_um_tx_segmenter_top.sv
rtl/rlcseg_checker.sv
tb/rlc_um_tx_segmenter_top_test.sv
